[sv/epr_pkg.sv]
// Package for the encoder position register map.
// Holds map constants, the command entry type and action codes; no dependencies.
package epr_pkg;

    localparam int unsigned COUNTS_PER_TURN = 4096;
    localparam int unsigned MAX_READ_BYTES  = 16;
    localparam int unsigned MAP_BYTES       = 7;
    localparam int unsigned QUEUE_DEPTH     = 2;

    localparam int unsigned POS_W    = 32;
    localparam int unsigned STAT_W   = 5;
    localparam int unsigned CNT_W    = 16;
    localparam int unsigned CUR_W    = 3;
    localparam int unsigned TURNS_W  = 20;
    localparam int unsigned ANGLE_W  = 12;
    localparam int unsigned FAIL_W   = 4;
    localparam int unsigned INDEX_W  = 8;
    localparam int unsigned BCOUNT_W = 5;

    localparam logic [1:0] ACT_UPDATE = 2'd0;
    localparam logic [1:0] ACT_SELECT = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;

    typedef enum logic [1:0] {
        OP_UPDATE,
        OP_SELECT,
        OP_READ
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [POS_W-1:0]    position;
        logic [STAT_W-1:0]   status;
        logic [CUR_W-1:0]    cursor;
        logic [BCOUNT_W-1:0] count;
    } t_cmd;

endpackage

[sv/encoder_position_register_map_top.sv]
// Top level of the encoder position register map.
// Ties together epr_front, epr_queue and epr_back; depends on epr_pkg.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  command  | start high, busy low | i_action i_turns i_angle i_sample_valid
//           |                      | i_failed_reads i_register_index i_byte_count
//  result   | o_strobe, one cycle  | o_read_data o_last_byte
//
// Update and select pass through the queue and take effect in the back end's registers.
// A read of n bytes streams out of the back end one byte a cycle.
// busy rises when the two-entry command queue is full.
// Reset is synchronous, active low, and clears the map and the queue.
// Results cannot be stalled; each byte stands for one cycle only.
module encoder_position_register_map_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_action,
    input  logic [epr_pkg::TURNS_W-1:0]  i_turns,
    input  logic [epr_pkg::ANGLE_W-1:0]  i_angle,
    input  logic                         i_sample_valid,
    input  logic [epr_pkg::FAIL_W-1:0]   i_failed_reads,
    input  logic [epr_pkg::INDEX_W-1:0]  i_register_index,
    input  logic [epr_pkg::BCOUNT_W-1:0] i_byte_count,
    output logic                         o_strobe,
    output logic [7:0]                   o_read_data,
    output logic                         o_last_byte
);

    epr_pkg::t_cmd front_cmd;
    epr_pkg::t_cmd head_cmd;
    logic          push, pop, empty, full;

    assign busy = full;

    epr_front u_front (
        .i_accept         (start && !full),
        .i_action         (i_action),
        .i_turns          (i_turns),
        .i_angle          (i_angle),
        .i_sample_valid   (i_sample_valid),
        .i_failed_reads   (i_failed_reads),
        .i_register_index (i_register_index),
        .i_byte_count     (i_byte_count),
        .o_push           (push),
        .o_cmd            (front_cmd)
    );

    epr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_empty (empty),
        .o_full  (full)
    );

    epr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (head_cmd),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_strobe    (o_strobe),
        .o_read_data (o_read_data),
        .o_last_byte (o_last_byte)
    );

endmodule

[sv/epr_front.sv]
// Front end of the encoder position register map: decodes and classifies beats.
// Builds queue entries of type epr_pkg::t_cmd; depends on epr_pkg.
module epr_front (
    input  logic                         i_accept,
    input  logic [1:0]                   i_action,
    input  logic [epr_pkg::TURNS_W-1:0]  i_turns,
    input  logic [epr_pkg::ANGLE_W-1:0]  i_angle,
    input  logic                         i_sample_valid,
    input  logic [epr_pkg::FAIL_W-1:0]   i_failed_reads,
    input  logic [epr_pkg::INDEX_W-1:0]  i_register_index,
    input  logic [epr_pkg::BCOUNT_W-1:0] i_byte_count,
    output logic                         o_push,
    output epr_pkg::t_cmd                o_cmd
);

    logic [epr_pkg::POS_W-1:0]    position;
    logic [epr_pkg::BCOUNT_W-1:0] count;
    logic [epr_pkg::CUR_W-1:0]    cursor;

    always_comb begin
        position = epr_pkg::POS_W'({12'd0, i_turns} * 32'(epr_pkg::COUNTS_PER_TURN))
                 + {20'd0, i_angle};
        if ({2'd0, i_byte_count} > 7'(epr_pkg::MAX_READ_BYTES)) begin
            count = epr_pkg::BCOUNT_W'(epr_pkg::MAX_READ_BYTES);
        end else begin
            count = i_byte_count;
        end
        if (i_register_index < epr_pkg::INDEX_W'(epr_pkg::MAP_BYTES)) begin
            cursor = i_register_index[epr_pkg::CUR_W-1:0];
        end else begin
            cursor = epr_pkg::CUR_W'(epr_pkg::MAP_BYTES);
        end

        o_cmd.position = position;
        o_cmd.status   = {i_failed_reads, i_sample_valid && (i_failed_reads == '0)};
        o_cmd.cursor   = cursor;
        o_cmd.count    = count;
        o_cmd.op       = epr_pkg::OP_UPDATE;
        o_push         = 1'b0;
        case (i_action)
            epr_pkg::ACT_UPDATE: begin
                o_cmd.op = epr_pkg::OP_UPDATE;
                o_push   = i_accept;
            end
            epr_pkg::ACT_SELECT: begin
                o_cmd.op = epr_pkg::OP_SELECT;
                o_push   = i_accept;
            end
            epr_pkg::ACT_READ: begin
                o_cmd.op = epr_pkg::OP_READ;
                o_push   = i_accept && (count != '0);
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

endmodule

[sv/epr_queue.sv]
// Command queue between front and back of the encoder position register map.
// Small register FIFO of epr_pkg::t_cmd entries; depends on epr_pkg.
module epr_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  epr_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output epr_pkg::t_cmd o_cmd,
    output logic          o_empty,
    output logic          o_full
);

    localparam int unsigned PTR_W = (epr_pkg::QUEUE_DEPTH > 1) ? $clog2(epr_pkg::QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(epr_pkg::QUEUE_DEPTH + 1);

    epr_pkg::t_cmd    r_mem [epr_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(epr_pkg::QUEUE_DEPTH));
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(epr_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(epr_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(epr_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("push lost");

endmodule

[sv/epr_back.sv]
// Back end of the encoder position register map: holds the map and streams reads.
// Consumes epr_pkg::t_cmd entries from the queue; depends on epr_pkg.
module epr_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  epr_pkg::t_cmd i_cmd,
    input  logic          i_empty,
    output logic          o_pop,
    output logic          o_strobe,
    output logic [7:0]    o_read_data,
    output logic          o_last_byte
);

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } t_state;

    localparam logic [epr_pkg::CUR_W-1:0] MAP_STATUS  = 3'd4;
    localparam logic [epr_pkg::CUR_W-1:0] MAP_COUNTER = 3'd5;
    localparam logic [epr_pkg::CUR_W-1:0] MAP_END     = epr_pkg::CUR_W'(epr_pkg::MAP_BYTES);

    t_state                       r_state, n_state;
    logic [epr_pkg::POS_W-1:0]    r_position, n_position;
    logic [epr_pkg::STAT_W-1:0]   r_status, n_status;
    logic [epr_pkg::CNT_W-1:0]    r_samples, n_samples;
    logic [epr_pkg::CUR_W-1:0]    r_cursor, n_cursor;
    logic [epr_pkg::BCOUNT_W-1:0] r_left, n_left;
    logic                         r_strobe, n_strobe;
    logic [7:0]                   r_data, n_data;
    logic                         r_last, n_last;
    logic [7:0]                   map_data;
    logic [epr_pkg::CUR_W-1:0]    ctr_sel;

    assign ctr_sel = r_cursor - MAP_COUNTER;

    always_comb begin
        if (r_cursor >= MAP_END) begin
            map_data = 8'd0;
        end else if (r_cursor == MAP_STATUS) begin
            map_data = {3'd0, r_status};
        end else if (r_cursor >= MAP_COUNTER) begin
            map_data = ctr_sel[0] ? r_samples[15:8] : r_samples[7:0];
        end else begin
            case (r_cursor[1:0])
                2'd0:    map_data = r_position[7:0];
                2'd1:    map_data = r_position[15:8];
                2'd2:    map_data = r_position[23:16];
                default: map_data = r_position[31:24];
            endcase
        end
    end

    assign o_pop = (r_state == ST_IDLE) && !i_empty;

    always_comb begin
        n_state    = r_state;
        n_position = r_position;
        n_status   = r_status;
        n_samples  = r_samples;
        n_cursor   = r_cursor;
        n_left     = r_left;
        n_strobe   = 1'b0;
        n_data     = r_data;
        n_last     = r_last;
        case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    case (i_cmd.op)
                        epr_pkg::OP_UPDATE: begin
                            n_position = i_cmd.position;
                            n_status   = i_cmd.status;
                            n_samples  = r_samples + 1'b1;
                        end
                        epr_pkg::OP_SELECT: begin
                            n_cursor = i_cmd.cursor;
                        end
                        epr_pkg::OP_READ: begin
                            n_left  = i_cmd.count;
                            n_state = ST_READ;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_READ: begin
                n_strobe = 1'b1;
                n_data   = map_data;
                n_last   = (r_left == 5'd1);
                n_left   = r_left - 1'b1;
                if (r_cursor < MAP_END) begin
                    n_cursor = r_cursor + 1'b1;
                end
                if (r_left == 5'd1) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_position <= '0;
            r_status   <= '0;
            r_samples  <= '0;
            r_cursor   <= '0;
            r_left     <= '0;
            r_strobe   <= 1'b0;
            r_data     <= '0;
            r_last     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_position <= n_position;
            r_status   <= n_status;
            r_samples  <= n_samples;
            r_cursor   <= n_cursor;
            r_left     <= n_left;
            r_strobe   <= n_strobe;
            r_data     <= n_data;
            r_last     <= n_last;
        end
    end

    assign o_strobe    = r_strobe;
    assign o_read_data = r_data;
    assign o_last_byte = r_last;

    a_read_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |=> r_strobe)
        else $error("read cycle without a byte");

    a_read_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> (r_left != '0))
        else $error("read with no bytes left");

    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_last) |=> !r_strobe)
        else $error("byte after last byte");

endmodule
